// ===== sv/tbl_pkg.sv =====
// tbl_pkg: shared types, codes and constants for the token bucket port queue limiter
// no dependencies
`timescale 1ns / 1ps

package tbl_pkg;

    localparam int NUM_QUEUES_DEF  = 64;
    localparam int STORE_DEPTH_DEF = 256;
    localparam int DRAIN_MAX_DEF   = 50;

    localparam logic [17:0] TOKEN_COST     = 18'd1000;
    localparam logic [17:0] TOKEN_MAX      = 18'h3ffff;
    localparam logic [19:0] MS_MAX         = 20'hfffff;
    localparam logic [6:0]  RESTART_FACTOR = 7'd100;
    localparam logic [15:0] RATE_RESET     = 16'd1000;
    localparam logic [8:0]  BURST_RESET    = 9'd50;

    localparam logic [0:0] REG_RATE  = 1'b0;
    localparam logic [0:0] REG_BURST = 1'b1;

    typedef enum logic [1:0] {
        CMD_ARRIVE  = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_SERVICE = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        K_PASS   = 3'd0,
        K_UNLIM  = 3'd1,
        K_QUEUED = 3'd2,
        K_DROP   = 3'd3,
        K_TX     = 3'd4,
        K_NONE   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] in_port_number;
        logic        is_action_reason;
        logic [15:0] packet_handle;
        logic [9:0]  elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  out_port;
        logic [15:0] out_handle;
        logic        last;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_DISPATCH,
        S_LONG_SCAN,
        S_LONG_DONE,
        S_POP_RD,
        S_POP_WR,
        S_PUSH,
        S_PUSH_LINK,
        S_MUL,
        S_REFILL,
        S_RR_SCAN,
        S_DRAIN_CHECK,
        S_FINISH
    } state_t;

endpackage

// ===== sv/token_bucket_port_queue_limiter_core.sv =====
// token_bucket_port_queue_limiter_core: top level, sequencer over shared stores
// depends on tbl_pkg and tbl_mul
`timescale 1ns / 1ps

// channel   signals                     rule
// command   start, busy, cmd_in         taken when start && !busy
// result    result_valid, result        valid for a single cycle per beat, no backpressure
// config    cfg_we, cfg_index, cfg_data written when cfg_we is high
//
// an arrival that passes is answered from dispatch; a queued arrival goes
// through the push states, first through a drop pass when one is needed,
// which scans the queue lengths one per cycle. service: a shift-add multiply
// for the refill, then per sent beat a round robin scan of up to NUM_QUEUES
// queue lengths and the pop store reads and writes. after reset and after
// restart a clearing pass rebuilds the free list and zeroes queue lengths;
// busy stays high meanwhile. results cannot be stalled.

module token_bucket_port_queue_limiter_core #(
    parameter int NUM_QUEUES  = tbl_pkg::NUM_QUEUES_DEF,
    parameter int STORE_DEPTH = tbl_pkg::STORE_DEPTH_DEF,
    parameter int DRAIN_MAX   = tbl_pkg::DRAIN_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tbl_pkg::in_item_t   cmd_in,
    output logic                result_valid,
    output tbl_pkg::out_item_t  result,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    localparam int QW = $clog2(NUM_QUEUES);
    localparam int SW = $clog2(STORE_DEPTH);
    localparam int LW = SW + 1;
    localparam int DW = $clog2(DRAIN_MAX + 1);
    localparam int CW = (SW > QW) ? SW : QW;

    // configuration
    logic [15:0] rate_reg;
    logic [8:0]  burst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= tbl_pkg::RATE_RESET;
            burst_reg <= tbl_pkg::BURST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbl_pkg::REG_RATE:  rate_reg  <= cfg_data;
                tbl_pkg::REG_BURST: burst_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // memories
    logic [15:0]   handle_mem [STORE_DEPTH];
    logic [SW-1:0] link_mem   [STORE_DEPTH];
    logic [SW-1:0] head_mem   [NUM_QUEUES];
    logic [SW-1:0] tail_mem   [NUM_QUEUES];
    logic [LW-1:0] len_mem    [NUM_QUEUES];

    logic          hs_we;
    logic [SW-1:0] hs_waddr;
    logic [15:0]   hs_wdata;
    logic [SW-1:0] hs_raddr;
    logic [15:0]   hs_rdata;
    logic          ln_we;
    logic [SW-1:0] ln_waddr, ln_wdata, ln_raddr, ln_rdata;
    logic          hd_we, tl_we, lq_we;
    logic [QW-1:0] hd_waddr, tl_waddr, lq_waddr;
    logic [SW-1:0] hd_wdata, tl_wdata;
    logic [LW-1:0] lq_wdata;
    logic [QW-1:0] hd_raddr, tl_raddr, lq_raddr;
    logic [SW-1:0] hd_rdata, tl_rdata;
    logic [LW-1:0] lq_rdata;

    always_ff @(posedge clk)
    begin
        if (hs_we)
            handle_mem[hs_waddr] <= hs_wdata;
        hs_rdata <= handle_mem[hs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ln_we)
            link_mem[ln_waddr] <= ln_wdata;
        ln_rdata <= link_mem[ln_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
            head_mem[hd_waddr] <= hd_wdata;
        hd_rdata <= head_mem[hd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tl_we)
            tail_mem[tl_waddr] <= tl_wdata;
        tl_rdata <= tail_mem[tl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lq_we)
            len_mem[lq_waddr] <= lq_wdata;
        lq_rdata <= len_mem[lq_raddr];
    end

    // control state
    tbl_pkg::state_t state_reg, state_next;
    logic [17:0]   tokens_reg, tokens_next;
    logic [19:0]   ms_reg, ms_next;
    logic [SW-1:0] free_reg, free_next;
    logic [LW-1:0] total_reg, total_next;
    logic [QW-1:0] rr_reg, rr_next;
    logic [CW:0]   cnt_reg, cnt_next;
    logic [DW-1:0] sent_reg, sent_next;
    logic          drain_reg, drain_next;

    // payload
    tbl_pkg::in_item_t item_reg, item_next;
    logic [QW-1:0] q_reg, q_next;
    logic [QW-1:0] best_reg, best_next;
    logic [LW-1:0] best_len_reg, best_len_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [LW-1:0] qlen_reg, qlen_next;
    logic          rv_next;
    tbl_pkg::out_item_t res_next, res_reg;
    logic          rv_reg;

    logic          mul_go, mul_done;
    logic [35:0]   mul_product;

    tbl_mul #(.AW(20), .BW(16)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .a       (ms_reg),
        .b       (rate_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tbl_pkg::S_CLEAR;
            tokens_reg <= '0;
            ms_reg     <= '0;
            free_reg   <= '0;
            total_reg  <= '0;
            rr_reg     <= '0;
            cnt_reg    <= '0;
            sent_reg   <= '0;
            drain_reg  <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tokens_reg <= tokens_next;
            ms_reg     <= ms_next;
            free_reg   <= free_next;
            total_reg  <= total_next;
            rr_reg     <= rr_next;
            cnt_reg    <= cnt_next;
            sent_reg   <= sent_next;
            drain_reg  <= drain_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        q_reg        <= q_next;
        best_reg     <= best_next;
        best_len_reg <= best_len_next;
        slot_reg     <= slot_next;
        qlen_reg     <= qlen_next;
        res_reg      <= res_next;
    end

    logic [17:0] cap;
    logic [27:0] cap_full;
    logic [36:0] refill_sum;
    logic [22:0] restart_full;
    logic [20:0] tick_sum;
    logic [QW-1:0] arr_port;
    logic          drop_needed;

    assign cap_full     = 28'(burst_reg) * 28'(tbl_pkg::TOKEN_COST);
    assign cap          = (cap_full > 28'(tbl_pkg::TOKEN_MAX)) ? tbl_pkg::TOKEN_MAX
                                                                : cap_full[17:0];
    assign refill_sum   = 37'(mul_product) + 37'(tokens_reg);
    assign restart_full = 23'(rate_reg) * 23'(tbl_pkg::RESTART_FACTOR);
    assign tick_sum     = 21'(ms_reg) + 21'(item_reg.elapsed_ms);
    assign arr_port     = item_reg.in_port_number[QW-1:0];
    assign drop_needed  = (total_reg != '0) &&
                          ((total_reg >= LW'(burst_reg)) || (total_reg >= LW'(STORE_DEPTH)));

    function automatic tbl_pkg::out_item_t mk(tbl_pkg::kind_t k, logic [QW-1:0] p,
                                              logic [15:0] h, logic l);
        tbl_pkg::out_item_t r;
        r.kind       = k;
        r.out_port   = 6'(p);
        r.out_handle = h;
        r.last       = l;
        return r;
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        tokens_next   = tokens_reg;
        ms_next       = ms_reg;
        free_next     = free_reg;
        total_next    = total_reg;
        rr_next       = rr_reg;
        cnt_next      = cnt_reg;
        sent_next     = sent_reg;
        drain_next    = drain_reg;
        item_next     = item_reg;
        q_next        = q_reg;
        best_next     = best_reg;
        best_len_next = best_len_reg;
        slot_next     = slot_reg;
        qlen_next     = qlen_reg;
        rv_next       = 1'b0;
        res_next      = res_reg;
        mul_go        = 1'b0;
        hs_we = 1'b0; hs_waddr = slot_reg; hs_wdata = item_reg.packet_handle;
        hs_raddr = slot_reg;
        ln_we = 1'b0; ln_waddr = slot_reg; ln_wdata = free_reg; ln_raddr = free_reg;
        hd_we = 1'b0; hd_waddr = q_reg; hd_wdata = slot_reg; hd_raddr = q_reg;
        tl_we = 1'b0; tl_waddr = q_reg; tl_wdata = slot_reg; tl_raddr = q_reg;
        lq_we = 1'b0; lq_waddr = q_reg; lq_wdata = '0; lq_raddr = q_reg;

        unique case (state_reg)
            tbl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next  = cmd_in;
                    state_next = tbl_pkg::S_DISPATCH;
                end
            end
            tbl_pkg::S_CLEAR:
            begin
                // rebuild free list i -> i+1 and zero the queue lengths
                ln_we    = 1'b1;
                ln_waddr = cnt_reg[SW-1:0];
                ln_wdata = SW'(cnt_reg[SW-1:0] + 1'b1);
                if (cnt_reg < (CW+1)'(NUM_QUEUES))
                begin
                    lq_we    = 1'b1;
                    lq_waddr = cnt_reg[QW-1:0];
                    lq_wdata = '0;
                end
                if (cnt_reg == (CW+1)'(((STORE_DEPTH > NUM_QUEUES) ? STORE_DEPTH
                                                                    : NUM_QUEUES) - 1))
                begin
                    cnt_next   = '0;
                    state_next = tbl_pkg::S_IDLE;
                    free_next  = '0;
                    total_next = '0;
                    rr_next    = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            tbl_pkg::S_DISPATCH:
            begin
                unique case (tbl_pkg::cmd_t'(item_reg.cmd))
                    tbl_pkg::CMD_TICK:
                    begin
                        ms_next    = (tick_sum > 21'(tbl_pkg::MS_MAX)) ? tbl_pkg::MS_MAX
                                                                       : tick_sum[19:0];
                        rv_next    = 1'b1;
                        res_next   = mk(tbl_pkg::K_NONE, '0, '0, 1'b1);
                        state_next = tbl_pkg::S_IDLE;
                    end
                    tbl_pkg::CMD_RESTART:
                    begin
                        tokens_next = (restart_full > 23'(tbl_pkg::TOKEN_MAX))
                                      ? tbl_pkg::TOKEN_MAX : restart_full[17:0];
                        ms_next     = '0;
                        rv_next     = 1'b1;
                        res_next    = mk(tbl_pkg::K_NONE, '0, '0, 1'b1);
                        cnt_next    = '0;
                        state_next  = tbl_pkg::S_CLEAR;
                    end
                    tbl_pkg::CMD_SERVICE:
                    begin
                        mul_go     = 1'b1;
                        sent_next  = '0;
                        state_next = tbl_pkg::S_MUL;
                    end
                    default:
                    begin
                        q_next = arr_port;
                        if (item_reg.is_action_reason)
                        begin
                            rv_next    = 1'b1;
                            res_next   = mk(tbl_pkg::K_UNLIM, arr_port,
                                            item_reg.packet_handle, 1'b1);
                            state_next = tbl_pkg::S_IDLE;
                        end
                        else if (total_reg == '0 && tokens_reg >= tbl_pkg::TOKEN_COST)
                        begin
                            tokens_next = tokens_reg - tbl_pkg::TOKEN_COST;
                            rv_next     = 1'b1;
                            res_next    = mk(tbl_pkg::K_PASS, arr_port,
                                             item_reg.packet_handle, 1'b1);
                            state_next  = tbl_pkg::S_IDLE;
                        end
                        else if (drop_needed)
                        begin
                            drain_next    = 1'b0;
                            cnt_next      = '0;
                            best_next     = '0;
                            best_len_next = '0;
                            lq_raddr      = '0;
                            state_next    = tbl_pkg::S_LONG_SCAN;
                        end
                        else
                        begin
                            lq_raddr   = arr_port;
                            tl_raddr   = arr_port;
                            ln_raddr   = free_reg;
                            state_next = tbl_pkg::S_PUSH;
                        end
                    end
                endcase
            end
            tbl_pkg::S_LONG_SCAN:
            begin
                // lq_rdata holds length of queue cnt_reg; strict > keeps lowest index
                if (lq_rdata > best_len_reg)
                begin
                    best_len_next = lq_rdata;
                    best_next     = cnt_reg[QW-1:0];
                end
                lq_raddr = QW'(cnt_reg + 1'b1);
                if (cnt_reg == (CW+1)'(NUM_QUEUES - 1))
                    state_next = tbl_pkg::S_LONG_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            tbl_pkg::S_LONG_DONE:
            begin
                q_next     = best_reg;
                qlen_next  = best_len_reg;
                hd_raddr   = best_reg;
                state_next = tbl_pkg::S_POP_RD;
            end
            tbl_pkg::S_POP_RD:
            begin
                // head slot available, fetch handle and link
                slot_next  = hd_rdata;
                hs_raddr   = hd_rdata;
                ln_raddr   = hd_rdata;
                state_next = tbl_pkg::S_POP_WR;
            end
            tbl_pkg::S_POP_WR:
            begin
                hd_we      = 1'b1;
                hd_waddr   = q_reg;
                hd_wdata   = ln_rdata;
                ln_we      = 1'b1;
                ln_waddr   = slot_reg;
                ln_wdata   = free_reg;
                free_next  = slot_reg;
                lq_we      = 1'b1;
                lq_waddr   = q_reg;
                lq_wdata   = qlen_reg - 1'b1;
                total_next = total_reg - 1'b1;
                rv_next    = 1'b1;
                if (drain_reg)
                begin
                    res_next   = mk(tbl_pkg::K_TX, q_reg, hs_rdata, 1'b0);
                    sent_next  = sent_reg + 1'b1;
                    state_next = tbl_pkg::S_DRAIN_CHECK;
                end
                else
                begin
                    res_next   = mk(tbl_pkg::K_DROP, q_reg, hs_rdata, 1'b0);
                    q_next     = arr_port;
                    state_next = tbl_pkg::S_FINISH;
                end
            end
            tbl_pkg::S_FINISH:
            begin
                // after a drop: fetch target queue state for the push
                lq_raddr   = arr_port;
                tl_raddr   = arr_port;
                ln_raddr   = free_reg;
                state_next = tbl_pkg::S_PUSH;
            end
            tbl_pkg::S_PUSH:
            begin
                slot_next  = free_reg;
                free_next  = ln_rdata;
                hs_we      = 1'b1;
                hs_waddr   = free_reg;
                lq_we      = 1'b1;
                lq_waddr   = arr_port;
                lq_wdata   = lq_rdata + 1'b1;
                tl_we      = 1'b1;
                tl_waddr   = arr_port;
                tl_wdata   = free_reg;
                total_next = total_reg + 1'b1;
                if (lq_rdata == '0)
                begin
                    hd_we    = 1'b1;
                    hd_waddr = arr_port;
                    hd_wdata = free_reg;
                    rv_next    = 1'b1;
                    res_next   = mk(tbl_pkg::K_QUEUED, arr_port,
                                    item_reg.packet_handle, 1'b1);
                    state_next = tbl_pkg::S_IDLE;
                end
                else
                    state_next = tbl_pkg::S_PUSH_LINK;
            end
            tbl_pkg::S_PUSH_LINK:
            begin
                // old tail (read before this beat's tail write) points at the new slot
                ln_we      = 1'b1;
                ln_waddr   = tl_rdata;
                ln_wdata   = slot_reg;
                rv_next    = 1'b1;
                res_next   = mk(tbl_pkg::K_QUEUED, arr_port,
                                item_reg.packet_handle, 1'b1);
                state_next = tbl_pkg::S_IDLE;
            end
            tbl_pkg::S_MUL:
            begin
                if (mul_done)
                    state_next = tbl_pkg::S_REFILL;
            end
            tbl_pkg::S_REFILL:
            begin
                if (refill_sum >= 37'(tbl_pkg::TOKEN_COST))
                begin
                    ms_next     = '0;
                    tokens_next = (refill_sum > 37'(cap)) ? cap : refill_sum[17:0];
                end
                drain_next = 1'b1;
                state_next = tbl_pkg::S_DRAIN_CHECK;
            end
            tbl_pkg::S_DRAIN_CHECK:
            begin
                if (sent_reg < DW'(DRAIN_MAX) && total_reg != '0 &&
                    tokens_reg >= tbl_pkg::TOKEN_COST)
                begin
                    cnt_next   = '0;
                    lq_raddr   = rr_reg;
                    state_next = tbl_pkg::S_RR_SCAN;
                end
                else
                begin
                    if (sent_reg == '0)
                    begin
                        rv_next  = 1'b1;
                        res_next = mk(tbl_pkg::K_NONE, '0, '0, 1'b1);
                    end
                    drain_next = 1'b0;
                    state_next = tbl_pkg::S_IDLE;
                end
            end
            tbl_pkg::S_RR_SCAN:
            begin
                q_next = QW'(rr_reg + cnt_reg[QW-1:0]);
                if (lq_rdata != '0)
                begin
                    qlen_next   = lq_rdata;
                    tokens_next = tokens_reg - tbl_pkg::TOKEN_COST;
                    rr_next     = QW'(q_next + 1'b1);
                    hd_raddr    = q_next;
                    state_next  = tbl_pkg::S_POP_RD;
                end
                else if (cnt_reg == (CW+1)'(NUM_QUEUES - 1))
                begin
                    drain_next = 1'b0;
                    state_next = tbl_pkg::S_IDLE;
                    if (sent_reg == '0)
                    begin
                        rv_next  = 1'b1;
                        res_next = mk(tbl_pkg::K_NONE, '0, '0, 1'b1);
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    lq_raddr = QW'(rr_reg + cnt_reg[QW-1:0] + 1'b1);
                end
            end
            default: state_next = tbl_pkg::S_IDLE;
        endcase
    end

    // a drained beat is last when nothing further will go out; patch it here
    logic more_tx;
    assign more_tx = (sent_reg < DW'(DRAIN_MAX)) && (total_reg != '0) &&
                     (tokens_reg >= tbl_pkg::TOKEN_COST);

    // tx beats are held in a register so the last flag is known
    tbl_pkg::out_item_t tx_hold_reg;
    logic               tx_hold_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tx_hold_v_reg <= 1'b0;
        else
            tx_hold_v_reg <= rv_reg && (res_reg.kind == tbl_pkg::K_TX);
    end

    always_ff @(posedge clk)
    begin
        tx_hold_reg <= res_reg;
    end

    logic tx_now;
    assign tx_now = rv_reg && (res_reg.kind == tbl_pkg::K_TX);

    // held tx beat is last only if drain found nothing more; its check has run by now
    logic tx_more;
    assign tx_more = (state_reg == tbl_pkg::S_RR_SCAN) || (state_reg == tbl_pkg::S_POP_RD) ||
                     tx_now || more_tx && (state_reg == tbl_pkg::S_DRAIN_CHECK);

    always_comb
    begin
        result_valid = tx_hold_v_reg || (rv_reg && !tx_now);
        if (tx_hold_v_reg)
        begin
            result      = tx_hold_reg;
            result.last = !tx_more;
        end
        else
            result = res_reg;
    end

    assign busy = (state_reg != tbl_pkg::S_IDLE) || rv_reg || tx_hold_v_reg;

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy not raised after accept");
    assert property (@(posedge clk) disable iff (!rst_n) total_reg <= LW'(STORE_DEPTH))
        else $error("total queued beyond store depth");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == tbl_pkg::S_CLEAR && $past(state_reg) == tbl_pkg::S_CLEAR)
                     |-> !result_valid)
        else $error("beat during clear");
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("beat while not busy");

endmodule

// ===== sv/tbl_mul.sv =====
// tbl_mul: shift-add multiplier, one multiplier bit per cycle
// depends on nothing but its ports
`timescale 1ns / 1ps

module tbl_mul #(
    parameter int AW = 20,
    parameter int BW = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic               done,
    output logic [AW+BW-1:0]   product
);
    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW+BW-1:0] mcand_reg, mcand_next;
    logic [BW-1:0]    mplier_reg, mplier_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    always_comb
    begin
        run_next    = run_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (go)
        begin
            run_next    = 1'b1;
            cnt_next    = CW'(BW);
            acc_next    = '0;
            mcand_next  = {{BW{1'b0}}, a};
            mplier_next = b;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                run_next = 1'b0;
        end
    end

    assign done    = run_reg && (cnt_reg == CW'(1));
    assign product = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

endmodule

// ===== tb/sv/tb_token_bucket_port_queue_limiter_core.sv =====
// testbench for token_bucket_port_queue_limiter_core: drives commands, predicts beats
// depends on tbl_pkg and the core rtl
`timescale 1ns / 1ps

module tb_token_bucket_port_queue_limiter_core;

    localparam int NQ = 64;
    localparam int SD = 256;
    localparam int DM = 50;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    tbl_pkg::in_item_t cmd_in = '0;
    logic result_valid;
    tbl_pkg::out_item_t result;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = tbl_pkg::REG_RATE;
    logic [15:0] cfg_data = '0;

    token_bucket_port_queue_limiter_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [15:0] rate_q;
    logic [8:0]  burst_q;
    logic [17:0] tokens;
    logic [19:0] ms_fill;
    logic [15:0] hstore [SD];
    logic [7:0]  links [SD];
    logic [7:0]  qhead [NQ];
    logic [7:0]  qtail [NQ];
    int          qlen [NQ];
    logic [7:0]  free_hd;
    int          total_q;
    logic [5:0]  rr_ptr;

    tbl_pkg::out_item_t expected_beats [$];
    int errors = 0;
    int cycles = 0;

    task automatic report(input string what, input tbl_pkg::out_item_t got,
                          input tbl_pkg::out_item_t want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void push_beat(tbl_pkg::kind_t k, logic [5:0] p, logic [15:0] h,
                                      logic l);
        tbl_pkg::out_item_t b;
        b.kind = k; b.out_port = p; b.out_handle = h; b.last = l;
        expected_beats.push_back(b);
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < SD; i++) links[i] = 8'(i + 1);
        for (int i = 0; i < NQ; i++) qlen[i] = 0;
        free_hd = 0; total_q = 0; rr_ptr = 0;
    endfunction

    function automatic void enqueue(int q, logic [15:0] h);
        logic [7:0] slot;
        slot = free_hd;
        free_hd = links[slot];
        hstore[slot] = h;
        if (qlen[q] == 0) qhead[q] = slot;
        else links[qtail[q]] = slot;
        qtail[q] = slot;
        qlen[q]++;
        total_q++;
    endfunction

    function automatic logic [15:0] dequeue(int q);
        logic [7:0] slot;
        logic [15:0] h;
        slot = qhead[q];
        h = hstore[slot];
        qhead[q] = links[slot];
        links[slot] = free_hd;
        free_hd = slot;
        qlen[q]--;
        total_q--;
        return h;
    endfunction

    function automatic void predict_limiter(tbl_pkg::in_item_t it);
        int port, best, n, q;
        longint t, cap;
        bit found;
        tbl_pkg::out_item_t lb;
        port = it.in_port_number % NQ;
        n = 0;
        case (tbl_pkg::cmd_t'(it.cmd))
            tbl_pkg::CMD_ARRIVE: begin
                if (it.is_action_reason)
                    push_beat(tbl_pkg::K_UNLIM, 6'(port), it.packet_handle, 1'b1);
                else if (total_q == 0 && tokens >= tbl_pkg::TOKEN_COST) begin
                    tokens -= tbl_pkg::TOKEN_COST;
                    push_beat(tbl_pkg::K_PASS, 6'(port), it.packet_handle, 1'b1);
                end else begin
                    if (total_q > 0 && (total_q >= burst_q || total_q >= SD)) begin
                        best = 0;
                        for (int i = 1; i < NQ; i++) if (qlen[i] > qlen[best]) best = i;
                        push_beat(tbl_pkg::K_DROP, 6'(best), dequeue(best), 1'b0);
                    end
                    enqueue(port, it.packet_handle);
                    push_beat(tbl_pkg::K_QUEUED, 6'(port), it.packet_handle, 1'b1);
                end
            end
            tbl_pkg::CMD_TICK: begin
                t = longint'(ms_fill) + it.elapsed_ms;
                ms_fill = (t > tbl_pkg::MS_MAX) ? tbl_pkg::MS_MAX : 20'(t);
                push_beat(tbl_pkg::K_NONE, '0, '0, 1'b1);
            end
            tbl_pkg::CMD_RESTART: begin
                t = longint'(rate_q) * tbl_pkg::RESTART_FACTOR;
                tokens = (t > tbl_pkg::TOKEN_MAX) ? tbl_pkg::TOKEN_MAX : 18'(t);
                ms_fill = 0;
                clear_model();
                push_beat(tbl_pkg::K_NONE, '0, '0, 1'b1);
            end
            default: begin
                t = longint'(ms_fill) * rate_q + tokens;
                if (t >= tbl_pkg::TOKEN_COST) begin
                    cap = longint'(burst_q) * tbl_pkg::TOKEN_COST;
                    if (cap > tbl_pkg::TOKEN_MAX) cap = tbl_pkg::TOKEN_MAX;
                    ms_fill = 0;
                    tokens = (t > cap) ? 18'(cap) : 18'(t);
                end
                while (n < DM && total_q > 0 && tokens >= tbl_pkg::TOKEN_COST) begin
                    found = 0; q = 0;
                    for (int i = 0; i < NQ && !found; i++) begin
                        q = (rr_ptr + i) % NQ;
                        if (qlen[q] != 0) found = 1;
                    end
                    if (!found) break;
                    tokens -= tbl_pkg::TOKEN_COST;
                    rr_ptr = 6'(q + 1);
                    push_beat(tbl_pkg::K_TX, 6'(q), dequeue(q), 1'b0);
                    n++;
                end
                if (n == 0) push_beat(tbl_pkg::K_NONE, '0, '0, 1'b1);
                else begin
                    lb = expected_beats.pop_back();
                    lb.last = 1'b1;
                    expected_beats.push_back(lb);
                end
            end
        endcase
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge clk) begin
        tbl_pkg::out_item_t w;
        if (rst_n && result_valid) begin
            if (expected_beats.size() == 0) report("unexpected beat", result, '0);
            else begin
                w = expected_beats.pop_front();
                if (result.kind !== w.kind) report("kind", result, w);
                if (result.out_port !== w.out_port) report("out_port", result, w);
                if (result.out_handle !== w.out_handle) report("out_handle", result, w);
                if (result.last !== w.last) report("last", result, w);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return;
        repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 80)) @(negedge clk);
    endtask

    task automatic send_item(tbl_pkg::in_item_t it);
        @(negedge clk);
        while (busy) @(negedge clk);
        start <= 1'b1;
        cmd_in <= it;
        @(posedge clk);
        predict_limiter(it);
        @(negedge clk);
        start <= 1'b0;
        random_gap();
    endtask

    function automatic tbl_pkg::in_item_t make_item(tbl_pkg::cmd_t c, int port, bit act,
                                                    int h, int ms);
        tbl_pkg::in_item_t it;
        it.cmd = c; it.in_port_number = 16'(port); it.is_action_reason = act;
        it.packet_handle = 16'(h); it.elapsed_ms = 10'(ms);
        return it;
    endfunction

    task automatic drain_wait();
        @(negedge clk);
        while (expected_beats.size() != 0 || busy) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        drain_wait();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tbl_pkg::REG_RATE) rate_q = val;
        else burst_q = val[8:0];
    endtask

    task automatic test_directed();
        send_item(make_item(tbl_pkg::CMD_ARRIVE, 16'hffff, 1, 16'hffff, 0));
        send_item(make_item(tbl_pkg::CMD_ARRIVE, 5, 0, 16'h0000, 1023));
        send_item(make_item(tbl_pkg::CMD_SERVICE, 0, 0, 0, 0));
        send_item(make_item(tbl_pkg::CMD_TICK, 0, 0, 0, 1023));
        send_item(make_item(tbl_pkg::CMD_SERVICE, 0, 0, 0, 0));
        send_item(make_item(tbl_pkg::CMD_ARRIVE, 3, 0, 16'h1234, 0));
        send_item(make_item(tbl_pkg::CMD_RESTART, 16'hffff, 1, 16'hffff, 1023));
        for (int i = 0; i < 6; i++)
            send_item(make_item(tbl_pkg::CMD_ARRIVE, i * 64 + (i % 2), 0, 16'ha000 + i, 0));
        send_item(make_item(tbl_pkg::CMD_TICK, 0, 0, 0, 0));
        send_item(make_item(tbl_pkg::CMD_SERVICE, 0, 0, 0, 0));
        send_item(make_item(tbl_pkg::CMD_SERVICE, 0, 0, 0, 0));
    endtask

    // small burst limit forces drops from the longest queue, ties to the lowest
    task automatic test_drop_longest();
        write_reg(tbl_pkg::REG_BURST, 16'd3);
        write_reg(tbl_pkg::REG_RATE, 16'd1);
        send_item(make_item(tbl_pkg::CMD_RESTART, 0, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            send_item(make_item(tbl_pkg::CMD_ARRIVE, (i % 3) + 7, 0, 16'h5000 + i, 0));
        send_item(make_item(tbl_pkg::CMD_TICK, 0, 0, 0, 1023));
        send_item(make_item(tbl_pkg::CMD_SERVICE, 0, 0, 0, 0));
        write_reg(tbl_pkg::REG_BURST, 16'd0);
        send_item(make_item(tbl_pkg::CMD_ARRIVE, 2, 0, 16'h7777, 0));
        send_item(make_item(tbl_pkg::CMD_ARRIVE, 9, 0, 16'h7778, 0));
    endtask

    // queue past the drain limit on a starved bucket, then a big refill drains 50 beats
    task automatic test_full_drain();
        write_reg(tbl_pkg::REG_BURST, 16'd256);
        write_reg(tbl_pkg::REG_RATE, 16'd1);
        send_item(make_item(tbl_pkg::CMD_RESTART, 0, 0, 0, 0));
        for (int i = 0; i < 60; i++) begin
            if (i < 3) send_item(make_item(tbl_pkg::CMD_ARRIVE, i, 0, i, 0));
            else send_item(make_item(tbl_pkg::CMD_ARRIVE, $urandom, 0, $urandom, 0));
        end
        write_reg(tbl_pkg::REG_RATE, 16'd65535);
        send_item(make_item(tbl_pkg::CMD_TICK, 0, 0, 0, 1023));
        send_item(make_item(tbl_pkg::CMD_SERVICE, 0, 0, 0, 0));
        send_item(make_item(tbl_pkg::CMD_SERVICE, 0, 0, 0, 0));
    endtask

    task automatic test_random(int count, int port_span);
        tbl_pkg::in_item_t it;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            it = make_item(r < 60 ? tbl_pkg::CMD_ARRIVE : r < 78 ? tbl_pkg::CMD_TICK
                           : r < 97 ? tbl_pkg::CMD_SERVICE : tbl_pkg::CMD_RESTART,
                           ($urandom_range(0, 1) ? $urandom : $urandom_range(0, port_span)),
                           $urandom_range(0, 9) == 0, $urandom, $urandom);
            send_item(it);
            if (i == count / 2) drain_wait();
        end
    endtask

    initial begin
        rate_q = tbl_pkg::RATE_RESET;
        burst_q = tbl_pkg::BURST_RESET;
        tokens = 0;
        ms_fill = 0;
        clear_model();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_drop_longest();
        test_full_drain();
        write_reg(tbl_pkg::REG_RATE, 16'd1);
        write_reg(tbl_pkg::REG_BURST, 16'd1);
        test_random(25, 3);
        write_reg(tbl_pkg::REG_RATE, 16'd700);
        write_reg(tbl_pkg::REG_BURST, 16'd12);
        test_random(20, 7);
        write_reg(tbl_pkg::REG_RATE, 16'($urandom_range(1, 65535)));
        write_reg(tbl_pkg::REG_BURST, 16'($urandom_range(1, 256)));
        test_random(20, 63);
        drain_wait();
        if (errors == 0 && expected_beats.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

// ===== token_bucket_port_queue_limiter_core.f =====
sv/tbl_pkg.sv
sv/tbl_mul.sv
sv/token_bucket_port_queue_limiter_core.sv
tb/sv/tb_token_bucket_port_queue_limiter_core.sv
